// ===== hdl/msaq_pkg.sv =====
package msaq_pkg;

    localparam int MAX_SLOTS   = 8;
    localparam int STORE_DEPTH = 64;

    localparam int SLOT_IW  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int SLOT_CW  = $clog2(MAX_SLOTS + 1);
    localparam int STORE_IW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int STORE_CW = $clog2(STORE_DEPTH + 1);
    localparam int SC_W     = (SLOT_CW > 4) ? SLOT_CW : 4;
    localparam int LIM_W    = (STORE_CW > 7) ? STORE_CW : 7;

    localparam int TIME_W = 40;
    localparam int SVC_W  = 32;
    localparam int T41_W  = 41;

    localparam logic [1:0] KIND_ADVANCE = 2'd0;
    localparam logic [1:0] KIND_QUERY   = 2'd1;
    localparam logic [1:0] KIND_SUBMIT  = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_BACKWARD  = 2'd2;
    localparam logic [1:0] ST_ZERO_SVC  = 2'd3;

    localparam logic CFG_SLOT_COUNT  = 1'b0;
    localparam logic CFG_QUEUE_LIMIT = 1'b1;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_DECIDE = 9'b000000010,
        S_RET    = 9'b000000100,
        S_SLOT   = 9'b000001000,
        S_START  = 9'b000010000,
        S_SUM    = 9'b000100000,
        S_COST   = 9'b001000000,
        S_FREE   = 9'b010000000,
        S_OUT    = 9'b100000000
    } t_state;

endpackage

// ===== hdl/multi_server_admission_queue_top.sv =====
// Admission-limited pool of service slots. Each transaction on the input
// channel is an advance, a query or a submit, and yields exactly one result
// transaction; any other kind yields an OK result. Items are handled one at
// a time by a small sequencer, and the input is not ready while an item is in
// work. An advance walks the whole completion store through its registered
// read port. A query scans the slots in use for the slot that frees earliest.
// A submit adds a search of the store's occupancy bits for a free entry, one
// entry per cycle. A finished result waits in the output register, and the
// next item is accepted meanwhile. Configuration writes are taken in any cycle.
module multi_server_admission_queue_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [1:0]                  i_kind,
    input  logic [msaq_pkg::TIME_W-1:0] i_now,
    input  logic [msaq_pkg::SVC_W-1:0]  i_service_time,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [1:0]                  o_status,
    output logic [msaq_pkg::T41_W-1:0]  o_cost,
    output logic [6:0]                  o_retired_count,
    output logic [6:0]                  o_queue_depth,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic                        i_cfg_index,
    input  logic [6:0]                  i_cfg_data
);

    msaq_pkg::t_state r_state, n_state;

    logic [3:0]                       r_slot_count;
    logic [6:0]                       r_queue_limit;
    logic [msaq_pkg::T41_W-1:0]       r_slot [msaq_pkg::MAX_SLOTS];
    logic [msaq_pkg::STORE_DEPTH-1:0] r_valid, n_valid;
    logic [msaq_pkg::STORE_CW-1:0]    r_outstanding, n_outstanding;
    logic [msaq_pkg::TIME_W-1:0]      r_last_time, n_last_time;

    logic [1:0]                  r_kind;
    logic [msaq_pkg::TIME_W-1:0] r_now;
    logic [msaq_pkg::SVC_W-1:0]  r_svc;

    logic [msaq_pkg::STORE_CW-1:0] r_idx, n_idx;
    logic                          r_pend, n_pend;
    logic [msaq_pkg::STORE_IW-1:0] r_pidx, n_pidx;
    logic [msaq_pkg::SLOT_CW-1:0]  r_sidx, n_sidx;
    logic [msaq_pkg::SLOT_IW-1:0]  r_best, n_best;
    logic [msaq_pkg::T41_W-1:0]    r_best_time, n_best_time;
    logic [msaq_pkg::T41_W-1:0]    r_start, n_start;
    logic [msaq_pkg::T41_W:0]      r_sum, n_sum;
    logic [msaq_pkg::T41_W-1:0]    r_done, n_done;

    logic [1:0]                    r_res_status, n_res_status;
    logic [msaq_pkg::T41_W-1:0]    r_res_cost, n_res_cost;
    logic [msaq_pkg::STORE_CW-1:0] r_res_ret, n_res_ret;

    logic                          r_out_valid, n_out_valid;
    logic [1:0]                    r_o_status;
    logic [msaq_pkg::T41_W-1:0]    r_o_cost;
    logic [6:0]                    r_o_ret;
    logic [6:0]                    r_o_depth;
    logic                          out_load;

    logic                          slot_we;
    logic [msaq_pkg::T41_W-1:0]    slot_wdata;
    logic                          ram_we;
    logic [msaq_pkg::STORE_IW-1:0] ram_raddr;
    logic [msaq_pkg::T41_W-1:0]    ram_rdata;

    logic [msaq_pkg::SLOT_CW-1:0]  nslots;
    logic [msaq_pkg::LIM_W-1:0]    limit;
    logic [msaq_pkg::T41_W-1:0]    now41;
    logic [msaq_pkg::T41_W:0]      diff;
    logic [msaq_pkg::T41_W-1:0]    done_sat;

    assign o_in_ready  = (r_state == msaq_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;

    // Slot count of zero acts as one, and the count is capped at the pool size.
    always_comb begin
        if (r_slot_count == 4'd0) begin
            nslots = msaq_pkg::SLOT_CW'(1);
        end else if (msaq_pkg::SC_W'(r_slot_count) > msaq_pkg::SC_W'(msaq_pkg::MAX_SLOTS)) begin
            nslots = msaq_pkg::SLOT_CW'(msaq_pkg::MAX_SLOTS);
        end else begin
            nslots = msaq_pkg::SLOT_CW'(r_slot_count);
        end
        if (msaq_pkg::LIM_W'(r_queue_limit) > msaq_pkg::LIM_W'(msaq_pkg::STORE_DEPTH)) begin
            limit = msaq_pkg::LIM_W'(msaq_pkg::STORE_DEPTH);
        end else begin
            limit = msaq_pkg::LIM_W'(r_queue_limit);
        end
    end

    assign now41    = {1'b0, r_now};
    assign diff     = r_sum - {2'b00, r_now};
    assign done_sat = r_sum[msaq_pkg::T41_W] ? {msaq_pkg::T41_W{1'b1}}
                                             : r_sum[msaq_pkg::T41_W-1:0];

    msaq_ram #(
        .WIDTH (msaq_pkg::T41_W),
        .DEPTH (msaq_pkg::STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_idx[msaq_pkg::STORE_IW-1:0]),
        .i_wdata (r_done),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state       = r_state;
        n_valid       = r_valid;
        n_outstanding = r_outstanding;
        n_last_time   = r_last_time;
        n_idx         = r_idx;
        n_pend        = r_pend;
        n_pidx        = r_pidx;
        n_sidx        = r_sidx;
        n_best        = r_best;
        n_best_time   = r_best_time;
        n_start       = r_start;
        n_sum         = r_sum;
        n_done        = r_done;
        n_res_status  = r_res_status;
        n_res_cost    = r_res_cost;
        n_res_ret     = r_res_ret;
        slot_we       = 1'b0;
        slot_wdata    = done_sat;
        ram_we        = 1'b0;
        ram_raddr     = r_idx[msaq_pkg::STORE_IW-1:0];
        out_load      = 1'b0;

        case (r_state)
            msaq_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = msaq_pkg::S_DECIDE;
                end
            end
            msaq_pkg::S_DECIDE: begin
                n_res_status = msaq_pkg::ST_OK;
                n_res_cost   = '0;
                n_res_ret    = '0;
                n_idx        = '0;
                n_pend       = 1'b0;
                n_sidx       = msaq_pkg::SLOT_CW'(1);
                n_best       = '0;
                n_best_time  = r_slot[0];
                if (r_kind != msaq_pkg::KIND_ADVANCE && r_kind != msaq_pkg::KIND_QUERY &&
                    r_kind != msaq_pkg::KIND_SUBMIT) begin
                    n_state = msaq_pkg::S_OUT;
                end else if (r_now < r_last_time) begin
                    n_res_status = msaq_pkg::ST_BACKWARD;
                    n_state      = msaq_pkg::S_OUT;
                end else if (r_kind == msaq_pkg::KIND_ADVANCE) begin
                    n_state = msaq_pkg::S_RET;
                end else if (r_svc == '0) begin
                    n_res_status = msaq_pkg::ST_ZERO_SVC;
                    n_state      = msaq_pkg::S_OUT;
                end else if (msaq_pkg::LIM_W'(r_outstanding) >= limit) begin
                    n_res_status = msaq_pkg::ST_FULL;
                    n_state      = msaq_pkg::S_OUT;
                end else begin
                    n_state = msaq_pkg::S_SLOT;
                end
            end
            msaq_pkg::S_RET: begin
                // Reads are issued one per cycle; each compare uses the data
                // returned for the address issued in the cycle before.
                if (r_idx < msaq_pkg::STORE_CW'(msaq_pkg::STORE_DEPTH)) begin
                    n_pend = 1'b1;
                    n_pidx = r_idx[msaq_pkg::STORE_IW-1:0];
                    n_idx  = r_idx + 1'b1;
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend && r_valid[r_pidx] && (ram_rdata <= now41)) begin
                    n_valid[r_pidx] = 1'b0;
                    n_res_ret       = r_res_ret + 1'b1;
                end
                if (r_idx == msaq_pkg::STORE_CW'(msaq_pkg::STORE_DEPTH) && !r_pend) begin
                    n_outstanding = r_outstanding - r_res_ret;
                    n_last_time   = r_now;
                    n_state       = msaq_pkg::S_OUT;
                end
            end
            msaq_pkg::S_SLOT: begin
                if (r_sidx < nslots) begin
                    if (r_slot[r_sidx[msaq_pkg::SLOT_IW-1:0]] < r_best_time) begin
                        n_best      = r_sidx[msaq_pkg::SLOT_IW-1:0];
                        n_best_time = r_slot[r_sidx[msaq_pkg::SLOT_IW-1:0]];
                    end
                    n_sidx = r_sidx + 1'b1;
                end else begin
                    n_state = msaq_pkg::S_START;
                end
            end
            msaq_pkg::S_START: begin
                n_start = (r_best_time > now41) ? r_best_time : now41;
                n_state = msaq_pkg::S_SUM;
            end
            msaq_pkg::S_SUM: begin
                n_sum   = {1'b0, r_start} + {{(msaq_pkg::T41_W + 1 - msaq_pkg::SVC_W){1'b0}}, r_svc};
                n_state = msaq_pkg::S_COST;
            end
            msaq_pkg::S_COST: begin
                n_res_cost = diff[msaq_pkg::T41_W] ? {msaq_pkg::T41_W{1'b1}}
                                                   : diff[msaq_pkg::T41_W-1:0];
                n_done     = done_sat;
                n_idx      = '0;
                if (r_kind == msaq_pkg::KIND_SUBMIT) begin
                    slot_we = 1'b1;
                    n_state = msaq_pkg::S_FREE;
                end else begin
                    n_state = msaq_pkg::S_OUT;
                end
            end
            msaq_pkg::S_FREE: begin
                // A free entry always exists here since the depth is below the limit.
                if (!r_valid[r_idx[msaq_pkg::STORE_IW-1:0]]) begin
                    ram_we                                  = 1'b1;
                    n_valid[r_idx[msaq_pkg::STORE_IW-1:0]]  = 1'b1;
                    n_outstanding                           = r_outstanding + 1'b1;
                    n_state                                 = msaq_pkg::S_OUT;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            msaq_pkg::S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    out_load = 1'b1;
                    n_state  = msaq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = msaq_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= msaq_pkg::S_IDLE;
            r_slot_count  <= 4'd1;
            r_queue_limit <= 7'd64;
            r_valid       <= '0;
            r_outstanding <= '0;
            r_last_time   <= '0;
            r_out_valid   <= 1'b0;
            r_pend        <= 1'b0;
            for (int k = 0; k < msaq_pkg::MAX_SLOTS; k++) begin
                r_slot[k] <= '0;
            end
        end else begin
            r_state       <= n_state;
            r_valid       <= n_valid;
            r_outstanding <= n_outstanding;
            r_last_time   <= n_last_time;
            r_out_valid   <= n_out_valid;
            r_pend        <= n_pend;
            if (slot_we) begin
                r_slot[r_best] <= slot_wdata;
            end
            if (i_cfg_valid) begin
                if (i_cfg_index == msaq_pkg::CFG_SLOT_COUNT) begin
                    r_slot_count <= i_cfg_data[3:0];
                end else begin
                    r_queue_limit <= i_cfg_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_kind <= i_kind;
            r_now  <= i_now;
            r_svc  <= i_service_time;
        end
        r_idx        <= n_idx;
        r_pidx       <= n_pidx;
        r_sidx       <= n_sidx;
        r_best       <= n_best;
        r_best_time  <= n_best_time;
        r_start      <= n_start;
        r_sum        <= n_sum;
        r_done       <= n_done;
        r_res_status <= n_res_status;
        r_res_cost   <= n_res_cost;
        r_res_ret    <= n_res_ret;
        if (out_load) begin
            r_o_status <= r_res_status;
            r_o_cost   <= r_res_cost;
            r_o_ret    <= 7'(r_res_ret);
            r_o_depth  <= 7'(r_outstanding);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_o_status;
    assign o_cost          = r_o_cost;
    assign o_retired_count = r_o_ret;
    assign o_queue_depth   = r_o_depth;

    // Between items the depth count must match the number of occupied entries.
    a_depth_matches_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == msaq_pkg::S_IDLE) |-> ($countones(r_valid) == int'(r_outstanding)))
        else $error("outstanding count differs from occupied store entries");

    a_free_entry_exists: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == msaq_pkg::S_FREE) |->
            (r_outstanding < msaq_pkg::STORE_CW'(msaq_pkg::STORE_DEPTH)))
        else $error("free entry search started on a full store");

    a_refused_no_cost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != msaq_pkg::ST_OK) |-> (o_cost == '0))
        else $error("refused transaction reports a nonzero cost");

    a_retire_only_on_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != msaq_pkg::ST_OK) |-> (o_retired_count == 7'd0))
        else $error("refused transaction reports retired jobs");

endmodule

// ===== hdl/msaq_ram.sv =====
module msaq_ram #(
    parameter int WIDTH = 41,
    parameter int DEPTH = 64
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
